// File: src/i2cm_pkg.sv
package i2cm_pkg;

	localparam int BUFFER_BYTES = 16;
	localparam int WORD_BYTES = 8;
	localparam int IDX_W = $clog2(BUFFER_BYTES);
	localparam int POS_W = $clog2(BUFFER_BYTES + 1);
	localparam int NUM_CMDS = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_CMD0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CMD1 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CMD2 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CMD3 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE = 3'd4;

	localparam logic [CFG_DATA_W-1:0] CMD0_RESET = 64'd199319843909;
	localparam logic [CFG_DATA_W-1:0] CMD1_RESET = 64'd461329560914;
	localparam logic [CFG_DATA_W-1:0] CMD2_RESET = 64'd474315843923;
	localparam logic [CFG_DATA_W-1:0] CMD3_RESET = 64'd495606456643;
	localparam logic [CFG_DATA_W-1:0] IDLE_RESET = 64'd199270097993;

	typedef logic [BUFFER_BYTES-1:0][7:0] text_t;

	typedef enum logic {
		EV_BUS,
		EV_TASK_DONE
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [7:0]  rx_byte;
		logic        read_request;
	} ev_t;

	typedef struct packed {
		logic        overflow;
		logic        command_done;
		logic [2:0]  mode;
		logic [7:0]  tx_byte;
		logic        tx_valid;
	} res_t;

	// Expands a packed word into a buffer image; everything from the first zero byte on is zero.
	function automatic text_t text_from_word(logic [CFG_DATA_W-1:0] w);
		text_t      t;
		logic       live;
		logic [7:0] b;
		live = 1'b1;
		for (int i = 0; i < BUFFER_BYTES; i++) begin
			b = (i < WORD_BYTES) ? w[8*(i % WORD_BYTES) +: 8] : 8'd0;
			t[i] = live ? b : 8'd0;
			live = live && (b != 8'd0);
		end
		return t;
	endfunction

endpackage

// File: src/i2cm_front.sv
module i2cm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [i2cm_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	output logic                             q_valid,
	output i2cm_pkg::ev_t                    q_ev,
	input  logic                             q_pop
);

	i2cm_pkg::ev_t                    qmem [i2cm_pkg::QUEUE_DEPTH];
	i2cm_pkg::ev_t                    ev_in;
	logic [i2cm_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [i2cm_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [i2cm_pkg::QCNT_W-1:0]      count_q;
	logic                             push;
	logic                             pop;

	always_comb begin
		ev_in.kind         = s_tuser ? i2cm_pkg::EV_TASK_DONE : i2cm_pkg::EV_BUS;
		ev_in.rx_byte      = s_tdata[7:0];
		ev_in.read_request = s_tdata[8];
	end

	assign s_tready = (count_q != i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_ev     = qmem[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_pop;

	always_ff @(posedge clk) begin
		if (push) begin
			qmem[wr_ptr_q] <= ev_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/i2cm_back.sv
module i2cm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               q_valid,
	input  i2cm_pkg::ev_t                      q_ev,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output i2cm_pkg::res_t                     res
);

	typedef enum logic [1:0] {
		PH_ADDR,
		PH_WRITE,
		PH_SEND,
		PH_LAST
	} phase_t;

	localparam logic [i2cm_pkg::POS_W-1:0] LAST_SLOT = i2cm_pkg::POS_W'(i2cm_pkg::BUFFER_BYTES - 1);
	localparam logic [i2cm_pkg::POS_W-1:0] FULL_POS  = i2cm_pkg::POS_W'(i2cm_pkg::BUFFER_BYTES);

	phase_t                              phase_q, phase_d;
	logic [i2cm_pkg::POS_W-1:0]          pos_q, pos_d;
	logic [2:0]                          mode_q, mode_d;
	i2cm_pkg::text_t                     status_q, status_d;
	logic [7:0]                          recv_q [i2cm_pkg::BUFFER_BYTES];
	logic [i2cm_pkg::CFG_DATA_W-1:0]     cmd_q [i2cm_pkg::NUM_CMDS];
	logic [i2cm_pkg::CFG_DATA_W-1:0]     idle_q;
	logic                                m_tvalid_q;
	i2cm_pkg::res_t                      res_q, res_d;
	logic                                take;
	logic                                recv_we;
	logic [i2cm_pkg::POS_W-1:0]          wr_pos;
	logic [i2cm_pkg::IDX_W-1:0]          wr_idx;
	i2cm_pkg::text_t                     rt_eff;
	i2cm_pkg::text_t                     copy_text;
	logic [i2cm_pkg::NUM_CMDS-1:0]       hit;

	// Exact string compare: every byte up to and including the terminator must agree.
	function automatic logic text_matches(i2cm_pkg::text_t rt,
			logic [i2cm_pkg::CFG_DATA_W-1:0] w);
		logic       run;
		logic       found;
		logic [7:0] b;
		run   = 1'b1;
		found = 1'b0;
		for (int i = 0; i <= i2cm_pkg::WORD_BYTES; i++) begin
			b = (i < i2cm_pkg::WORD_BYTES) ? w[8*(i % i2cm_pkg::WORD_BYTES) +: 8] : 8'd0;
			run = run && (rt[i] == b);
			if (run && (rt[i] == 8'd0)) begin
				found = 1'b1;
			end
		end
		return found && 1'b1;
	endfunction

	assign take     = q_valid && (!m_tvalid_q || m_tready);
	assign q_pop    = take;
	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	assign wr_pos = (pos_q > LAST_SLOT) ? LAST_SLOT : pos_q;
	assign wr_idx = wr_pos[i2cm_pkg::IDX_W-1:0];

	// The terminator lands at wr_pos; everything before it belongs to the current write.
	always_comb begin
		for (int i = 0; i < i2cm_pkg::BUFFER_BYTES; i++) begin
			rt_eff[i]    = (i2cm_pkg::IDX_W'(i) == wr_idx) ? q_ev.rx_byte : recv_q[i];
			copy_text[i] = (i2cm_pkg::POS_W'(i) < wr_pos) ? recv_q[i] : 8'd0;
		end
		for (int k = 0; k < i2cm_pkg::NUM_CMDS; k++) begin
			hit[k] = text_matches(rt_eff, cmd_q[k]);
		end
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		mode_d   = mode_q;
		status_d = status_q;
		recv_we  = 1'b0;
		res_d    = '0;
		if (q_ev.kind == i2cm_pkg::EV_TASK_DONE) begin
			mode_d   = 3'd0;
			status_d = i2cm_pkg::text_from_word(idle_q);
		end else begin
			case (phase_q)
				PH_ADDR: begin
					pos_d = '0;
					if (q_ev.read_request) begin
						res_d.tx_byte  = status_q[0];
						res_d.tx_valid = 1'b1;
						pos_d          = i2cm_pkg::POS_W'(1);
						phase_d        = (status_q[0] == 8'd0) ? PH_LAST : PH_SEND;
					end else begin
						phase_d = PH_WRITE;
					end
				end
				PH_WRITE: begin
					if (q_ev.rx_byte != 8'd0 && pos_q >= LAST_SLOT) begin
						res_d.overflow = 1'b1;
					end else begin
						recv_we = 1'b1;
						pos_d   = wr_pos + 1'b1;
						if (q_ev.rx_byte == 8'd0) begin
							if (hit[0]) begin
								mode_d = 3'd1;
							end else if (hit[1]) begin
								mode_d = 3'd2;
							end else if (hit[2]) begin
								mode_d = 3'd3;
							end else if (hit[3]) begin
								mode_d = 3'd4;
							end else begin
								mode_d = 3'd0;
							end
							status_d           = copy_text;
							res_d.command_done = 1'b1;
							phase_d            = PH_ADDR;
						end
					end
				end
				PH_SEND: begin
					res_d.tx_valid = 1'b1;
					if (pos_q < FULL_POS) begin
						res_d.tx_byte = status_q[pos_q[i2cm_pkg::IDX_W-1:0]];
						pos_d         = pos_q + 1'b1;
					end
					if (res_d.tx_byte == 8'd0) begin
						phase_d = PH_LAST;
					end
				end
				PH_LAST: begin
					phase_d = PH_ADDR;
				end
				default: begin
					phase_d = PH_ADDR;
				end
			endcase
		end
		res_d.mode = mode_d;
	end

	always_ff @(posedge clk) begin
		if (take && recv_we) begin
			recv_q[wr_idx] <= q_ev.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ADDR;
			pos_q      <= '0;
			mode_q     <= 3'd0;
			status_q   <= i2cm_pkg::text_from_word(i2cm_pkg::IDLE_RESET);
			cmd_q[0]   <= i2cm_pkg::CMD0_RESET;
			cmd_q[1]   <= i2cm_pkg::CMD1_RESET;
			cmd_q[2]   <= i2cm_pkg::CMD2_RESET;
			cmd_q[3]   <= i2cm_pkg::CMD3_RESET;
			idle_q     <= i2cm_pkg::IDLE_RESET;
			m_tvalid_q <= 1'b0;
			res_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					i2cm_pkg::CFG_CMD0: cmd_q[0] <= cfg_data;
					i2cm_pkg::CFG_CMD1: cmd_q[1] <= cfg_data;
					i2cm_pkg::CFG_CMD2: cmd_q[2] <= cfg_data;
					i2cm_pkg::CFG_CMD3: cmd_q[3] <= cfg_data;
					i2cm_pkg::CFG_IDLE: idle_q   <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				phase_q    <= phase_d;
				pos_q      <= pos_d;
				mode_q     <= mode_d;
				status_q   <= status_d;
				res_q      <= res_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/i2c_slave_command_mailbox_core.sv
// I2C slave command mailbox. Each request on the slave side is one event: a bus byte event
// (tuser 0) or a local task-finished notice (tuser 1), and each gives exactly one result on
// the master side. Writes gather a zero-terminated command of up to fifteen characters,
// which is matched against four programmable command words and becomes the status text;
// reads return that status text up to its terminator. Throughput is one request per clock
// while the master side accepts results: a two-entry queue sits between the input stage
// and the execution stage, and the execution stage handles a whole event combinationally
// into an output register, so an accepted request is stored in the queue and its result is
// presented from the output register. The user must write the command words and idle text
// through the configuration port only while no request is in flight; the block does not enforce this.
module i2c_slave_command_mailbox_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [i2cm_pkg::S_TDATA_W-1:0]     s_tdata,   // rx_byte[7:0], read_request[8]
	input  logic                               s_tuser,   // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [i2cm_pkg::M_TDATA_W-1:0]     m_tdata    // tx_valid, tx_byte, mode, command_done, overflow
);

	logic            q_valid;
	logic            q_pop;
	i2cm_pkg::ev_t   q_ev;
	i2cm_pkg::res_t  res;

	i2cm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ev     (q_ev),
		.q_pop    (q_pop)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ev      (q_ev),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tdata = {2'b00, res};

`ifndef ASSERT_OFF
	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.tx_valid |-> res.tx_byte == 8'd0)
		else $error("transmit byte set without a transmit");

	a_done_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.command_done && res.overflow))
		else $error("command completion and overflow on the same event");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.mode <= 3'd4)
		else $error("mode out of range");

	a_tx_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.tx_valid |-> !res.command_done && !res.overflow)
		else $error("transmit on a write event");
`endif

endmodule
